### design/tfcm_pkg.sv
// Shared types, register indexes, reset values and channel helpers of the false-color map.
package tfcm_pkg;

    localparam int TEMP_BITS_DEF = 12;
    localparam int COLOR_BITS    = 16;
    localparam int CH_BITS       = 6;
    localparam int NUM_CH        = 3;
    localparam int BAND_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [BAND_BITS-1:0]    t_band;
    typedef logic [COLOR_BITS-1:0]   t_color;
    typedef logic [CH_BITS-1:0]      t_chan;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_band BAND_COLD_CLAMP = 3'd0;
    localparam t_band BAND_COLD_GRAD  = 3'd1;
    localparam t_band BAND_NEUT_GRAD  = 3'd2;
    localparam t_band BAND_WARM_GRAD  = 3'd3;
    localparam t_band BAND_HOT_CLAMP  = 3'd4;

    localparam t_cfg_idx REG_COLD_LIMIT    = 3'd0;
    localparam t_cfg_idx REG_ROOM_LEVEL    = 3'd1;
    localparam t_cfg_idx REG_HIGHLIGHT     = 3'd2;
    localparam t_cfg_idx REG_HOT_LIMIT     = 3'd3;
    localparam t_cfg_idx REG_COLOR_COLD    = 3'd4;
    localparam t_cfg_idx REG_COLOR_NEUTRAL = 3'd5;
    localparam t_cfg_idx REG_COLOR_WARM    = 3'd6;
    localparam t_cfg_idx REG_COLOR_HOT     = 3'd7;

    localparam int COLD_LIMIT_RST = -100;
    localparam int ROOM_LEVEL_RST = 220;
    localparam int HIGHLIGHT_RST  = 360;
    localparam int HOT_LIMIT_RST  = 700;

    localparam t_color COLOR_COLD_RST    = 16'd16;
    localparam t_color COLOR_NEUTRAL_RST = 16'd65535;
    localparam t_color COLOR_WARM_RST    = 16'd64800;
    localparam t_color COLOR_HOT_RST     = 16'd32768;

    // Channel 0 is red (5 bits), 1 is green (6 bits), 2 is blue (5 bits).
    function automatic t_chan get_chan(input t_color color, input int ch);
        t_chan res;
        case (ch)
            0:       res = {1'b0, color[15:11]};
            1:       res = color[10:5];
            default: res = {1'b0, color[4:0]};
        endcase
        return res;
    endfunction

endpackage

### design/temperature_false_color_map.sv
// Temperature false-color map: signed temperature in, RGB565 color and band out.
// Stages: classify, segment, numerator, then the divider.
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// The six-step restoring divider that finishes each channel sets the depth.
// Reset (synchronous, active low) empties the pipeline and restores the default palette.
module temperature_false_color_map #(
    parameter int TEMP_BITS = tfcm_pkg::TEMP_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tfcm_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [tfcm_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: [TEMP_BITS-1:0] temperature, rest zero padding.
    input  logic [((TEMP_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: [15:0] pixel_color (red 15-11, green 10-5, blue 4-0).
    output logic [tfcm_pkg::COLOR_BITS-1:0]    m_axis_tdata,
    // tuser: [2:0] band.
    output logic [tfcm_pkg::BAND_BITS-1:0]     m_axis_tuser
);

    // The numerator a*(d-n) + b*n never exceeds 63*d, so it fits six more bits
    // than the segment width and the quotient fits in six bits.
    localparam int NW    = TEMP_BITS + tfcm_pkg::CH_BITS;
    localparam int QB    = tfcm_pkg::CH_BITS;
    localparam int NCH   = tfcm_pkg::NUM_CH;
    localparam int NSTG  = 3 + QB;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are only expected while idle, so
    // the classify and segment stages read them directly.
    // ------------------------------------------------------------------
    logic signed [TEMP_BITS-1:0] r_cold_limit;
    logic signed [TEMP_BITS-1:0] r_room_level;
    logic signed [TEMP_BITS-1:0] r_highlight;
    logic signed [TEMP_BITS-1:0] r_hot_limit;
    tfcm_pkg::t_color            r_color_cold;
    tfcm_pkg::t_color            r_color_neutral;
    tfcm_pkg::t_color            r_color_warm;
    tfcm_pkg::t_color            r_color_hot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cold_limit    <= TEMP_BITS'(tfcm_pkg::COLD_LIMIT_RST);
            r_room_level    <= TEMP_BITS'(tfcm_pkg::ROOM_LEVEL_RST);
            r_highlight     <= TEMP_BITS'(tfcm_pkg::HIGHLIGHT_RST);
            r_hot_limit     <= TEMP_BITS'(tfcm_pkg::HOT_LIMIT_RST);
            r_color_cold    <= tfcm_pkg::COLOR_COLD_RST;
            r_color_neutral <= tfcm_pkg::COLOR_NEUTRAL_RST;
            r_color_warm    <= tfcm_pkg::COLOR_WARM_RST;
            r_color_hot     <= tfcm_pkg::COLOR_HOT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tfcm_pkg::REG_COLD_LIMIT:    r_cold_limit    <= i_cfg_data[TEMP_BITS-1:0];
                tfcm_pkg::REG_ROOM_LEVEL:    r_room_level    <= i_cfg_data[TEMP_BITS-1:0];
                tfcm_pkg::REG_HIGHLIGHT:     r_highlight     <= i_cfg_data[TEMP_BITS-1:0];
                tfcm_pkg::REG_HOT_LIMIT:     r_hot_limit     <= i_cfg_data[TEMP_BITS-1:0];
                tfcm_pkg::REG_COLOR_COLD:    r_color_cold    <= i_cfg_data;
                tfcm_pkg::REG_COLOR_NEUTRAL: r_color_neutral <= i_cfg_data;
                tfcm_pkg::REG_COLOR_WARM:    r_color_warm    <= i_cfg_data;
                tfcm_pkg::REG_COLOR_HOT:     r_color_hot     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. All stages move together; the pipeline advances when
    // the output register is empty or its transfer completes this cycle.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic            w_adv;

    assign w_adv         = m_axis_tready || !r_vld[NSTG-1];
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: classify the temperature. The clamp tests run first, cold before
    // hot, then the gradient bounds in order, so unordered thresholds resolve predictably.
    // ------------------------------------------------------------------
    logic signed [TEMP_BITS-1:0] w_temp;
    tfcm_pkg::t_band             n_s1_band;
    logic signed [TEMP_BITS-1:0] r_s1_temp;
    tfcm_pkg::t_band             r_s1_band;

    assign w_temp = s_axis_tdata[TEMP_BITS-1:0];

    always_comb begin
        if (w_temp <= r_cold_limit) begin
            n_s1_band = tfcm_pkg::BAND_COLD_CLAMP;
        end else if (w_temp >= r_hot_limit) begin
            n_s1_band = tfcm_pkg::BAND_HOT_CLAMP;
        end else if (w_temp < r_room_level) begin
            n_s1_band = tfcm_pkg::BAND_COLD_GRAD;
        end else if (w_temp < r_highlight) begin
            n_s1_band = tfcm_pkg::BAND_NEUT_GRAD;
        end else begin
            n_s1_band = tfcm_pkg::BAND_WARM_GRAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_temp <= w_temp;
            r_s1_band <= n_s1_band;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the segment end points and colors, and form the
    // segment width d and the offset n. A clamp uses d = 1, n = 0 with both
    // end colors equal, which makes the arithmetic below return that color.
    // ------------------------------------------------------------------
    logic signed [TEMP_BITS-1:0] w_lo;
    logic signed [TEMP_BITS-1:0] w_hi;
    logic                        w_clamp;
    tfcm_pkg::t_color            w_ca;
    tfcm_pkg::t_color            w_cb;
    logic signed [TEMP_BITS:0]   w_d_full;
    logic signed [TEMP_BITS:0]   w_n_full;
    logic [TEMP_BITS-1:0]        n_s2_d;
    logic [TEMP_BITS-1:0]        n_s2_n;
    logic [TEMP_BITS-1:0]        r_s2_d;
    logic [TEMP_BITS-1:0]        r_s2_n;
    tfcm_pkg::t_color            r_s2_ca;
    tfcm_pkg::t_color            r_s2_cb;
    tfcm_pkg::t_band             r_s2_band;

    always_comb begin
        w_lo    = r_cold_limit;
        w_hi    = r_room_level;
        w_clamp = 1'b0;
        w_ca    = r_color_cold;
        w_cb    = r_color_cold;
        case (r_s1_band)
            tfcm_pkg::BAND_COLD_GRAD: begin
                w_lo = r_cold_limit;
                w_hi = r_room_level;
                w_ca = r_color_cold;
                w_cb = r_color_neutral;
            end
            tfcm_pkg::BAND_NEUT_GRAD: begin
                w_lo = r_room_level;
                w_hi = r_highlight;
                w_ca = r_color_neutral;
                w_cb = r_color_warm;
            end
            tfcm_pkg::BAND_WARM_GRAD: begin
                w_lo = r_highlight;
                w_hi = r_hot_limit;
                w_ca = r_color_warm;
                w_cb = r_color_hot;
            end
            tfcm_pkg::BAND_HOT_CLAMP: begin
                w_clamp = 1'b1;
                w_ca    = r_color_hot;
                w_cb    = r_color_hot;
            end
            default: begin
                w_clamp = 1'b1;
            end
        endcase

        w_d_full = {w_hi[TEMP_BITS-1], w_hi} - {w_lo[TEMP_BITS-1], w_lo};
        w_n_full = {r_s1_temp[TEMP_BITS-1], r_s1_temp} - {w_lo[TEMP_BITS-1], w_lo};

        if (w_clamp) begin
            n_s2_d = TEMP_BITS'(1);
            n_s2_n = '0;
        end else begin
            // Both are known nonnegative and below 2**TEMP_BITS here.
            n_s2_d = w_d_full[TEMP_BITS-1:0];
            n_s2_n = w_n_full[TEMP_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_d    <= n_s2_d;
            r_s2_n    <= n_s2_n;
            r_s2_ca   <= w_ca;
            r_s2_cb   <= w_cb;
            r_s2_band <= r_s1_band;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerator per channel, a*(d-n) + b*n.
    // ------------------------------------------------------------------
    logic [TEMP_BITS-1:0] w_dmn;
    logic [NW-1:0]        n_s3_num [NCH];
    logic [NW-1:0]        r_s3_num [NCH];
    logic [TEMP_BITS-1:0] r_s3_d;
    tfcm_pkg::t_band      r_s3_band;

    assign w_dmn = r_s2_d - r_s2_n;

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            n_s3_num[ch] = NW'(tfcm_pkg::get_chan(r_s2_ca, ch)) * NW'(w_dmn)
                         + NW'(tfcm_pkg::get_chan(r_s2_cb, ch)) * NW'(r_s2_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_num  <= n_s3_num;
            r_s3_d    <= r_s2_d;
            r_s3_band <= r_s2_band;
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 to 9: restoring division by d, one quotient bit per stage,
    // most significant bit first. The last stage is the output register.
    // ------------------------------------------------------------------
    logic [NW-1:0]        r_dv_rem  [QB-1][NCH];
    logic [TEMP_BITS-1:0] r_dv_d    [QB-1];
    tfcm_pkg::t_chan      r_dv_q    [QB][NCH];
    tfcm_pkg::t_band      r_dv_band [QB];

    for (genvar gs = 0; gs < QB; gs++) begin : g_div
        logic [NW-1:0]        w_rem_in [NCH];
        tfcm_pkg::t_chan      w_q_in   [NCH];
        logic [TEMP_BITS-1:0] w_d_in;
        tfcm_pkg::t_band      w_band_in;
        logic [NW-1:0]        w_dsh;
        logic [NW-1:0]        n_rem    [NCH];
        tfcm_pkg::t_chan      n_q      [NCH];

        if (gs == 0) begin : g_first
            assign w_rem_in  = r_s3_num;
            assign w_d_in    = r_s3_d;
            assign w_band_in = r_s3_band;
            always_comb begin
                for (int ch = 0; ch < NCH; ch++) begin
                    w_q_in[ch] = '0;
                end
            end
        end else begin : g_next
            assign w_rem_in  = r_dv_rem[gs-1];
            assign w_d_in    = r_dv_d[gs-1];
            assign w_band_in = r_dv_band[gs-1];
            assign w_q_in    = r_dv_q[gs-1];
        end

        assign w_dsh = NW'(w_d_in) << (QB - 1 - gs);

        always_comb begin
            for (int ch = 0; ch < NCH; ch++) begin
                n_q[ch] = w_q_in[ch];
                if (w_rem_in[ch] >= w_dsh) begin
                    n_rem[ch]          = w_rem_in[ch] - w_dsh;
                    n_q[ch][QB-1-gs]   = 1'b1;
                end else begin
                    n_rem[ch]          = w_rem_in[ch];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_q[gs]    <= n_q;
                r_dv_band[gs] <= w_band_in;
            end
        end

        if (gs < QB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dv_rem[gs] <= n_rem;
                    r_dv_d[gs]   <= w_d_in;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: repack the three quotients as RGB565.
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {r_dv_q[QB-1][0][4:0], r_dv_q[QB-1][1][5:0], r_dv_q[QB-1][2][4:0]};
    assign m_axis_tuser  = r_dv_band[QB-1];

endmodule
